[hdl/sfs_pkg.sv]
// Shared types and constants for the sample ring FIFO with statistics.
package sfs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned STORE_DEPTH_DEF  = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 64;

  // Fixed port widths
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned TOT_W  = 32;

  // Capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture the request and launch the store read
    logic exec;    // complete the request and register the result
  } cmd_t;

endpackage

[hdl/sfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sfs_ctrl.sv]
// Controller state machine: accepts a request and sequences read and update.
module sfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output sfs_pkg::cmd_t cmd_o
);
  import sfs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath
  assign busy         = (state_q != ST_IDLE);
  assign cmd_o.accept = (state_q == ST_IDLE) && start;
  assign cmd_o.exec   = (state_q == ST_EXEC);

endmodule

[hdl/sfs_datapath.sv]
// Datapath: pointers, occupancy, statistics, capacity register and sample store.
module sfs_datapath #(
  parameter int unsigned STORE_DEPTH  = sfs_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = sfs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sfs_pkg::cmd_t              cmd_i,
  input  sfs_pkg::op_e               op_i,
  input  logic [sfs_pkg::DATA_W-1:0] sample_data_i,
  input  logic                       cfg_we_i,
  input  logic [sfs_pkg::CNT_W-1:0]  cfg_data_i,
  output logic                       result_valid_o,
  output logic                       ok_o,
  output logic [sfs_pkg::DATA_W-1:0] read_data_o,
  output logic [sfs_pkg::CNT_W-1:0]  fill_count_o,
  output logic [sfs_pkg::CNT_W-1:0]  free_space_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  output logic [sfs_pkg::CNT_W-1:0]  peak_fill_o,
  output logic [sfs_pkg::TOT_W-1:0]  pushes_total_o,
  output logic [sfs_pkg::TOT_W-1:0]  pops_total_o
);
  import sfs_pkg::*;

  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
  localparam int unsigned CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;

  // Request registers
  op_e                     op_q;
  logic [SAMPLE_WIDTH-1:0] data_q;

  // FIFO state
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] hw_q, hw_d;
  logic [TOT_W-1:0] push_cnt_q, push_cnt_d;
  logic [TOT_W-1:0] pop_cnt_q, pop_cnt_d;
  logic [CNT_W-1:0] cap_q;

  // Result registers
  logic              valid_q;
  logic              ok_q;
  logic [DATA_W-1:0] rdata_q;
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  free_q;
  logic              empty_q;
  logic              full_q;

  logic [CNT_W-1:0]        cap_eff;
  logic [PTR_W:0]          rp_inc;
  logic [PTR_W:0]          wp_inc;
  logic                    push_ok;
  logic                    read_ok;
  logic                    ok_d;
  logic                    ram_we;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;
  logic [DATA_W-1:0]       rdata_d;

  // Capacity saturated to 1..STORE_DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_q) > STORE_DEPTH) begin
      cap_eff = CNT_W'(STORE_DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Pointer increments, wrapped against the capacity below
  assign rp_inc = {1'b0, rp_q} + (PTR_W + 1)'(1);
  assign wp_inc = {1'b0, wp_q} + (PTR_W + 1)'(1);

  assign push_ok = (op_q == OP_PUSH) && (occ_q < cap_eff);
  assign read_ok = ((op_q == OP_POP) || (op_q == OP_PEEK)) && (occ_q != '0);
  assign ram_we  = cmd_i.exec && push_ok;

  // Next state of the ring and statistics
  always_comb begin
    rp_d       = rp_q;
    wp_d       = wp_q;
    occ_d      = occ_q;
    hw_d       = hw_q;
    push_cnt_d = push_cnt_q;
    pop_cnt_d  = pop_cnt_q;
    ok_d       = 1'b0;
    rdata_d    = '0;
    case (op_q)
      OP_PUSH: begin
        if (push_ok) begin
          wp_d       = (CMP_W'(wp_inc) >= CMP_W'(cap_eff)) ? '0 : wp_inc[PTR_W-1:0];
          occ_d      = occ_q + CNT_W'(1);
          push_cnt_d = push_cnt_q + TOT_W'(1);
          ok_d       = 1'b1;
          if (occ_q + CNT_W'(1) > hw_q) hw_d = occ_q + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (read_ok) begin
          ok_d    = 1'b1;
          rdata_d = DATA_W'(ram_rdata);
          if (op_q == OP_POP) begin
            rp_d      = (CMP_W'(rp_inc) >= CMP_W'(cap_eff)) ? '0 : rp_inc[PTR_W-1:0];
            occ_d     = occ_q - CNT_W'(1);
            pop_cnt_d = pop_cnt_q + TOT_W'(1);
          end
        end
      end
      default: begin
        rp_d       = '0;
        wp_d       = '0;
        occ_d      = '0;
        hw_d       = '0;
        push_cnt_d = '0;
        pop_cnt_d  = '0;
        ok_d       = 1'b1;
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      data_q <= sample_data_i[SAMPLE_WIDTH-1:0];
    end
  end

  // Control state, capacity register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      wp_q       <= '0;
      occ_q      <= '0;
      hw_q       <= '0;
      push_cnt_q <= '0;
      pop_cnt_q  <= '0;
      cap_q      <= CAP_RESET;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.exec) begin
        rp_q       <= rp_d;
        wp_q       <= wp_d;
        occ_q      <= occ_d;
        hw_q       <= hw_d;
        push_cnt_q <= push_cnt_d;
        pop_cnt_q  <= pop_cnt_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q    <= ok_d;
      rdata_q <= rdata_d;
      fill_q  <= occ_d;
      free_q  <= (occ_d >= cap_eff) ? '0 : cap_eff - occ_d;
      empty_q <= (occ_d == '0);
      full_q  <= (occ_d >= cap_eff);
    end
  end

  // Sample store: read launched on accept at the current read pointer
  sfs_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (data_q),
    .re_i    (cmd_i.accept),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = valid_q;
  assign ok_o           = ok_q;
  assign read_data_o    = rdata_q;
  assign fill_count_o   = fill_q;
  assign free_space_o   = free_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;
  assign peak_fill_o    = hw_q;
  assign pushes_total_o = push_cnt_q;
  assign pops_total_o   = pop_cnt_q;

endmodule

[hdl/sample_ring_fifo_with_stats.sv]
// Top level of the sample ring FIFO with usage statistics.
//
// Each request (push, pop, peek or clear) is sequenced as follows: the accept
// cycle launches the read of the sample store at the read pointer, and the
// next cycle completes the operation and registers the result. The result is
// shown for one cycle with result_valid_o high, and the next request is taken
// in that same cycle, so requests do not overlap: the wait between them is
// set by the registered read of the store. The receiver cannot stall results.
// busy is high in the cycle after each accept. The capacity register may be
// written whenever busy is low; follow a capacity change with a clear.
module sample_ring_fifo_with_stats #(
  parameter int unsigned STORE_DEPTH  = sfs_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = sfs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  sfs_pkg::op_e               op_i,
  input  logic [sfs_pkg::DATA_W-1:0] sample_data_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sfs_pkg::CNT_W-1:0]  cfg_data_i,
  output logic                       result_valid_o,
  output logic                       ok_o,
  output logic [sfs_pkg::DATA_W-1:0] read_data_o,
  output logic [sfs_pkg::CNT_W-1:0]  fill_count_o,
  output logic [sfs_pkg::CNT_W-1:0]  free_space_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  output logic [sfs_pkg::CNT_W-1:0]  peak_fill_o,
  output logic [sfs_pkg::TOT_W-1:0]  pushes_total_o,
  output logic [sfs_pkg::TOT_W-1:0]  pops_total_o
);
  import sfs_pkg::*;

  cmd_t cmd;

  // Configuration writes are taken between requests
  assign cfg_ready_o = ~busy;

  sfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  sfs_datapath #(
    .STORE_DEPTH  (STORE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .sample_data_i  (sample_data_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .read_data_o    (read_data_o),
    .fill_count_o   (fill_count_o),
    .free_space_o   (free_space_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .peak_fill_o    (peak_fill_o),
    .pushes_total_o (pushes_total_o),
    .pops_total_o   (pops_total_o)
  );

endmodule

[tb/sv/sample_ring_fifo_with_stats_test.sv]
// Self-checking testbench for the sample ring FIFO with usage statistics.
`timescale 1ns / 1ps

module sample_ring_fifo_with_stats_test;
  import sfs_pkg::*;

  localparam int unsigned RING_DEPTH    = STORE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 2;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Status returned by every request
  typedef struct packed {
    logic             ok;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_space;
    logic             is_empty;
    logic             is_full;
    logic [CNT_W-1:0] peak_fill;
    logic [TOT_W-1:0] pushes_total;
    logic [TOT_W-1:0] pops_total;
  } fifo_status_t;

  // Pending stimulus: a request, a capacity write, or a wait for all results
  typedef enum {JOB_REQ, JOB_CAPACITY, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e        kind;
    op_e              op;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0] capacity;
    int unsigned      gap_pct;
  } fifo_job_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  op_e              op_i           = OP_PUSH;
  logic [DATA_W-1:0] sample_data_i = '0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i     = '0;
  logic             result_valid_o;
  logic             ok_o;
  logic [DATA_W-1:0] read_data_o;
  logic [CNT_W-1:0] fill_count_o;
  logic [CNT_W-1:0] free_space_o;
  logic             is_empty_o;
  logic             is_full_o;
  logic [CNT_W-1:0] peak_fill_o;
  logic [TOT_W-1:0] pushes_total_o;
  logic [TOT_W-1:0] pops_total_o;

  sample_ring_fifo_with_stats dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .sample_data_i  (sample_data_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .read_data_o    (read_data_o),
    .fill_count_o   (fill_count_o),
    .free_space_o   (free_space_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .peak_fill_o    (peak_fill_o),
    .pushes_total_o (pushes_total_o),
    .pops_total_o   (pops_total_o)
  );

  // Clock: 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the FIFO state
  logic [DATA_W-1:0] shadow_store [RING_DEPTH];
  int unsigned       rd_ptr     = 0;
  int unsigned       wr_ptr     = 0;
  int unsigned       occupancy  = 0;
  int unsigned       high_water = 0;
  logic [TOT_W-1:0]  push_count = '0;
  logic [TOT_W-1:0]  pop_count  = '0;
  logic [CNT_W-1:0]  cap_reg    = CAP_RESET;

  fifo_job_t    op_backlog [$];
  fifo_status_t status_expect_q [$];
  int unsigned  in_flight    = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  cur_gap_pct  = 0;
  int unsigned  mismatches   = 0;
  logic         nxt_start;
  logic         nxt_cfg_valid;

  // Pointer step: wraps to zero at or beyond the effective capacity
  function automatic int unsigned ring_next(int unsigned ptr, int unsigned cap);
    return (ptr + 1 >= cap) ? 0 : ptr + 1;
  endfunction

  // Applies one request to the shadow state and returns the status it yields
  function automatic fifo_status_t predict_fifo_op(op_e op, logic [DATA_W-1:0] data);
    fifo_status_t st;
    int unsigned  cap;
    st  = '0;
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > RING_DEPTH) cap = RING_DEPTH;
    case (op)
      OP_PUSH: begin
        if (occupancy < cap) begin
          shadow_store[wr_ptr % RING_DEPTH] = data;
          wr_ptr = ring_next(wr_ptr, cap);
          occupancy++;
          push_count++;
          if (occupancy > high_water) high_water = occupancy;
          st.ok = 1'b1;
        end
      end
      OP_POP, OP_PEEK: begin
        if (occupancy != 0) begin
          st.read_data = shadow_store[rd_ptr % RING_DEPTH];
          if (op == OP_POP) begin
            rd_ptr = ring_next(rd_ptr, cap);
            occupancy--;
            pop_count++;
          end
          st.ok = 1'b1;
        end
      end
      default: begin
        rd_ptr     = 0;
        wr_ptr     = 0;
        occupancy  = 0;
        high_water = 0;
        push_count = '0;
        pop_count  = '0;
        st.ok      = 1'b1;
      end
    endcase
    st.fill_count   = occupancy[CNT_W-1:0];
    st.free_space   = (occupancy >= cap) ? '0 : CNT_W'(cap - occupancy);
    st.is_empty     = (occupancy == 0);
    st.is_full      = (occupancy >= cap);
    st.peak_fill    = high_water[CNT_W-1:0];
    st.pushes_total = push_count;
    st.pops_total   = pop_count;
    return st;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_request(op_e op, logic [DATA_W-1:0] data);
    fifo_job_t j;
    j.kind     = JOB_REQ;
    j.op       = op;
    j.data     = data;
    j.capacity = '0;
    j.gap_pct  = cur_gap_pct;
    op_backlog.push_back(j);
  endtask

  task automatic add_capacity(logic [CNT_W-1:0] capacity);
    fifo_job_t j;
    j.kind     = JOB_CAPACITY;
    j.op       = OP_CLEAR;
    j.data     = '0;
    j.capacity = capacity;
    j.gap_pct  = 0;
    op_backlog.push_back(j);
  endtask

  task automatic add_drain();
    fifo_job_t j;
    j.kind     = JOB_DRAIN;
    j.op       = OP_CLEAR;
    j.data     = '0;
    j.capacity = '0;
    j.gap_pct  = 0;
    op_backlog.push_back(j);
  endtask

  // Driver: presents requests and capacity writes from the backlog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      nxt_start     = start;
      nxt_cfg_valid = cfg_valid_i;
      if (result_valid_o && in_flight != 0) in_flight--;
      if (start && !busy) begin
        status_expect_q.push_back(predict_fifo_op(op_i, sample_data_i));
        in_flight++;
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_reg       = cfg_data_i;
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_start && !nxt_cfg_valid && op_backlog.size() != 0) begin
        if (op_backlog[0].kind == JOB_REQ) begin
          quiet_cycles = 0;
          if ($urandom_range(99) >= op_backlog[0].gap_pct) begin
            op_i          <= op_backlog[0].op;
            sample_data_i <= op_backlog[0].data;
            nxt_start     = 1'b1;
            void'(op_backlog.pop_front());
          end
        end else if (in_flight == 0) begin
          // idle long enough to cover the block's latency
          if (quiet_cycles < SETTLE_CYCLES) begin
            quiet_cycles++;
          end else begin
            quiet_cycles = 0;
            if (op_backlog[0].kind == JOB_CAPACITY) begin
              cfg_data_i    <= op_backlog[0].capacity;
              nxt_cfg_valid = 1'b1;
            end
            void'(op_backlog.pop_front());
          end
        end else begin
          quiet_cycles = 0;
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // Monitor: checks each result against the oldest expected status
  always @(posedge clk_i) begin
    fifo_status_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{ok_o, read_data_o, fill_count_o, free_space_o, is_empty_o, is_full_o,
              peak_fill_o, pushes_total_o, pops_total_o};
      if (status_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = status_expect_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: status mismatch", $realtime);
            $display("  exp ok=%0d rd=%h fill=%0d free=%0d empty=%0d full=%0d peak=%0d push=%0d pop=%0d",
                     want.ok, want.read_data, want.fill_count, want.free_space, want.is_empty,
                     want.is_full, want.peak_fill, want.pushes_total, want.pops_total);
            $display("  got ok=%0d rd=%h fill=%0d free=%0d empty=%0d full=%0d peak=%0d push=%0d pop=%0d",
                     got.ok, got.read_data, got.fill_count, got.free_space, got.is_empty,
                     got.is_full, got.peak_fill, got.pushes_total, got.pops_total);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus plan, reset and end of run
  initial begin
    int unsigned gap_plan [4];
    int unsigned push_pct;
    int unsigned r;
    logic [CNT_W-1:0] capacity;
    gap_plan = '{0, 57, 0, 17};
    for (int i = 0; i < RING_DEPTH; i++) shadow_store[i] = '0;

    // Directed: empty refusals, data extremes, every op
    cur_gap_pct = 0;
    add_request(OP_PEEK, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_PUSH, '0);
    add_request(OP_PUSH, '1);
    add_request(OP_PEEK, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_CLEAR, rand_word());
    // capacity of one: push refused when full
    add_capacity(9'd1);
    add_request(OP_CLEAR, '0);
    add_request(OP_PUSH, rand_word());
    add_request(OP_PUSH, rand_word());
    add_request(OP_POP, rand_word());
    // capacity zero behaves as one
    add_capacity('0);
    add_request(OP_CLEAR, '0);
    add_request(OP_PUSH, rand_word());
    add_request(OP_PUSH, rand_word());
    add_request(OP_PEEK, rand_word());
    // capacity above the store depth saturates
    add_capacity('1);
    add_request(OP_CLEAR, '0);
    add_request(OP_PUSH, rand_word());
    add_request(OP_POP, rand_word());
    // capacity of two: pointer wrap
    add_capacity(9'd2);
    add_request(OP_CLEAR, '0);
    add_request(OP_PUSH, rand_word());
    add_request(OP_PUSH, rand_word());
    add_request(OP_PUSH, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_PUSH, rand_word());
    add_request(OP_POP, rand_word());
    add_request(OP_POP, rand_word());

    // Fill the whole store once so every entry holds a written sample
    add_drain();
    add_capacity(CAP_RESET);
    add_request(OP_CLEAR, '0);
    for (int i = 0; i <= RING_DEPTH; i++) add_request(OP_PUSH, rand_word());
    for (int i = 0; i < RING_DEPTH + 4; i++)
      add_request(($urandom_range(3) == 0) ? OP_PEEK : OP_POP, rand_word());

    // Random phases: capacity change, usually a clear, then biased traffic
    for (int p = 0; p < 12; p++) begin
      cur_gap_pct = gap_plan[p % 4];
      add_drain();
      case ($urandom_range(7))
        0:       capacity = 9'd1;
        1:       capacity = 9'd2;
        2, 3:    capacity = CNT_W'($urandom_range(16, 1));
        4:       capacity = CNT_W'($urandom_range(256, 17));
        5:       capacity = CAP_RESET;
        6:       capacity = '0;
        default: capacity = CNT_W'($urandom_range(511, 257));
      endcase
      add_capacity(capacity);
      if ($urandom_range(99) < 80) add_request(OP_CLEAR, rand_word());
      case (p % 3)
        0:       push_pct = 70;
        1:       push_pct = 50;
        default: push_pct = 30;
      endcase
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(99);
        if (r < 3)
          add_request(OP_CLEAR, rand_word());
        else if (r < 15)
          add_request(OP_PEEK, rand_word());
        else if ($urandom_range(99) < push_pct)
          add_request(OP_PUSH, rand_word());
        else
          add_request(OP_POP, rand_word());
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || start || cfg_valid_i || in_flight != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES + 2) @(posedge clk_i);

    if (mismatches == 0 && status_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
